@@ rtl/core/ptl_pkg.sv @@
// ----------------------------------------------------------------------------
// ptl_pkg
// Types and constants shared by the postfix tree linker modules.
// ----------------------------------------------------------------------------
package ptl_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_BITS   = 16;
    localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] KIND_LEAF   = 3'd0;
    localparam logic [2:0] KIND_UNARY  = 3'd1;
    localparam logic [2:0] KIND_RIGHT  = 3'd2;
    localparam logic [2:0] KIND_BINARY = 3'd3;
    localparam logic [2:0] KIND_ROOT   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_EXTRA = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [ADDR_BITS-1:0] node_addr;
        logic [2:0]           node_kind;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] out_node;
        logic [ADDR_BITS-1:0] left_link;
        logic [ADDR_BITS-1:0] right_link;
        logic                 tree_done;
        logic [1:0]           status;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_HOLD      = 2'b00,
        OP_LOAD_PREV = 2'b01,
        OP_LOAD_NEXT = 2'b10
    } cell_op_t;

    typedef struct packed {
        logic     en;
        cell_op_t head_op;
        cell_op_t body_op;
    } chain_ctrl_t;

endpackage

@@ rtl/core/ptl_cell.sv @@
// ----------------------------------------------------------------------------
// ptl_cell
// One stack entry: holds, takes the entry above, or takes the entry below.
// ----------------------------------------------------------------------------
module ptl_cell (
    input  logic                          clk,
    input  logic                          en,
    input  ptl_pkg::cell_op_t             op,
    input  logic [ptl_pkg::ADDR_BITS-1:0] prev_data,
    input  logic [ptl_pkg::ADDR_BITS-1:0] next_data,
    output logic [ptl_pkg::ADDR_BITS-1:0] data
);

    logic [ptl_pkg::ADDR_BITS-1:0] data_reg;
    logic [ptl_pkg::ADDR_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            ptl_pkg::OP_HOLD:      data_next = data_reg;
            ptl_pkg::OP_LOAD_PREV: data_next = prev_data;
            ptl_pkg::OP_LOAD_NEXT: data_next = next_data;
            default:               data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

@@ rtl/core/ptl_chain.sv @@
// ----------------------------------------------------------------------------
// ptl_chain
// Row of stack cells; entry 0 is the top of stack.
// ----------------------------------------------------------------------------
module ptl_chain (
    input  logic                          clk,
    input  ptl_pkg::chain_ctrl_t          ctrl,
    input  logic [ptl_pkg::ADDR_BITS-1:0] push_addr,
    output logic [ptl_pkg::ADDR_BITS-1:0] top0,
    output logic [ptl_pkg::ADDR_BITS-1:0] top1
);

    logic [ptl_pkg::ADDR_BITS-1:0] cell_data [ptl_pkg::STACK_DEPTH];

    for (genvar i = 0; i < ptl_pkg::STACK_DEPTH; i++)
    begin : g_cell
        logic [ptl_pkg::ADDR_BITS-1:0] prev_d;
        logic [ptl_pkg::ADDR_BITS-1:0] next_d;
        ptl_pkg::cell_op_t             op_d;

        if (i == 0)
        begin : g_head
            assign prev_d = push_addr;
            assign op_d   = ctrl.head_op;
        end
        else
        begin : g_body
            assign prev_d = cell_data[i-1];
            assign op_d   = ctrl.body_op;
        end

        if (i == ptl_pkg::STACK_DEPTH - 1)
        begin : g_tail
            assign next_d = '0;
        end
        else
        begin : g_mid
            assign next_d = cell_data[i+1];
        end

        ptl_cell u_cell (
            .clk       (clk),
            .en        (ctrl.en),
            .op        (op_d),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[i])
        );
    end

    assign top0 = cell_data[0];
    assign top1 = cell_data[1];

endmodule

@@ rtl/core/postfix_tree_linker.sv @@
// ----------------------------------------------------------------------------
// postfix_tree_linker
// Links postfix-ordered expression tree nodes through a shifting node stack.
// Output: each accepted item yields a registered result.
// Throughput: one item per cycle while in_stall is low; the stack cells shift by
// at most one entry per item, so both pops and the push resolve in that cycle.
// Reset: asynchronous; clears stack count and output valid, entries unwritten.
// ----------------------------------------------------------------------------
module postfix_tree_linker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ptl_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output ptl_pkg::out_item_t out_item
);

    logic [ptl_pkg::CNT_BITS-1:0]  count_reg;
    logic [ptl_pkg::CNT_BITS-1:0]  count_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    ptl_pkg::out_item_t            out_item_reg;
    ptl_pkg::out_item_t            out_item_next;
    ptl_pkg::chain_ctrl_t          ctrl;
    logic [ptl_pkg::ADDR_BITS-1:0] top0;
    logic [ptl_pkg::ADDR_BITS-1:0] top1;
    logic                          accept;
    logic                          need_right;
    logic                          need_left;
    logic [1:0]                    pop_cnt;
    logic [ptl_pkg::CNT_BITS-1:0]  after_cnt;
    logic                          few;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign need_right = (in_item.node_kind == ptl_pkg::KIND_RIGHT) ||
                        (in_item.node_kind == ptl_pkg::KIND_BINARY) ||
                        (in_item.node_kind == ptl_pkg::KIND_ROOT);
    assign need_left  = (in_item.node_kind == ptl_pkg::KIND_UNARY) ||
                        (in_item.node_kind == ptl_pkg::KIND_BINARY) ||
                        (in_item.node_kind == ptl_pkg::KIND_ROOT);
    assign pop_cnt    = {1'b0, need_right} + {1'b0, need_left};
    assign few        = count_reg < ptl_pkg::CNT_BITS'(pop_cnt);
    assign after_cnt  = count_reg - ptl_pkg::CNT_BITS'(pop_cnt);

    always_comb
    begin
        out_item_next.out_node   = in_item.node_addr;
        out_item_next.left_link  = '0;
        out_item_next.right_link = '0;
        out_item_next.tree_done  = 1'b0;
        out_item_next.status     = ptl_pkg::ST_OK;
        count_next               = count_reg;
        ctrl.en                  = 1'b0;
        ctrl.head_op             = ptl_pkg::OP_LOAD_PREV;
        ctrl.body_op             = ptl_pkg::OP_HOLD;

        if (need_right)
        begin
            out_item_next.right_link = top0;
        end
        if (need_left)
        begin
            out_item_next.left_link = need_right ? top1 : top0;
        end

        case (pop_cnt)
            2'd0:    ctrl.body_op = ptl_pkg::OP_LOAD_PREV;
            2'd1:    ctrl.body_op = ptl_pkg::OP_HOLD;
            default: ctrl.body_op = ptl_pkg::OP_LOAD_NEXT;
        endcase

        if (few)
        begin
            out_item_next.left_link  = '0;
            out_item_next.right_link = '0;
            out_item_next.status     = ptl_pkg::ST_FEW;
            count_next               = '0;
        end
        else if (in_item.node_kind == ptl_pkg::KIND_ROOT)
        begin
            count_next = '0;
            if (after_cnt != '0)
            begin
                out_item_next.status = ptl_pkg::ST_EXTRA;
            end
            else
            begin
                out_item_next.tree_done = 1'b1;
            end
        end
        else if (after_cnt >= ptl_pkg::CNT_BITS'(ptl_pkg::STACK_DEPTH))
        begin
            out_item_next.status = ptl_pkg::ST_FULL;
            count_next           = '0;
        end
        else
        begin
            ctrl.en    = accept;
            count_next = after_cnt + 1'b1;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    ptl_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .push_addr (in_item.node_addr),
        .top0      (top0),
        .top1      (top1)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
